[rtl/bcle_pkg.sv]
// Shared constants for the bounded circular list engine.
// No dependencies; imported by the engine top level.
`default_nettype none

package bcle_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [1:0] FUNC_INS_FRONT = 2'd0;
  localparam logic [1:0] FUNC_INS_END   = 2'd1;
  localparam logic [1:0] FUNC_DELETE    = 2'd2;
  localparam logic [1:0] FUNC_SHOW      = 2'd3;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_SHOWN     = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

endpackage

`default_nettype wire

[rtl/bounded_circular_list_engine_top.sv]
// Bounded circular list engine: ordered list of signed 32-bit values in a ring RAM.
// Depends on bcle_pkg and bcle_ram.
//
// One item at a time. Inserts complete straight from idle. Delete scans the ring
// entry by entry (one RAM read, then a compare), then moves each later entry down
// one place to close the gap (each move is one RAM read followed by one RAM
// write-back). Show reads the entries out one by one, held by any output stall.
// A new item is taken only in idle with the result register free or draining.
`default_nettype none

module bounded_circular_list_engine_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  func,
  input  wire logic signed [31:0]          value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2:0]                       status,
  output logic signed [31:0]               item_value,
  output logic                             last_of_run
);
  import bcle_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DREAD  = 3'd1;
  localparam logic [2:0] S_DCMP   = 3'd2;
  localparam logic [2:0] S_SREAD  = 3'd3;
  localparam logic [2:0] S_SWRITE = 3'd4;
  localparam logic [2:0] S_VREAD  = 3'd5;
  localparam logic [2:0] S_VOUT   = 3'd6;

  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

  logic [2:0]        state;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [DATA_W-1:0] key;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              full;
  logic [IDX_W-1:0]  head_dec;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_inc2;

  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CAP_CNT);
  assign head_dec = (head == '0) ? IDX_LAST : head - IDX_W'(1);
  assign idx_inc  = idx + CNT_W'(1);
  assign idx_inc2 = idx + CNT_W'(2);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ring_pos(head, count);
    ram_wdata = value;
    ram_re    = 1'b0;
    ram_raddr = ring_pos(head, idx);
    out_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        out_load = accept && (func == FUNC_INS_FRONT || func == FUNC_INS_END ||
                              count == '0);
        if (accept && !full && func == FUNC_INS_FRONT) begin
          ram_we    = 1'b1;
          ram_waddr = head_dec;
        end else if (accept && !full && func == FUNC_INS_END) begin
          ram_we    = 1'b1;
        end
      end
      S_DREAD, S_VREAD: begin
        ram_re = 1'b1;
      end
      S_DCMP: begin
        out_load = !(idx_inc < count);
      end
      S_SREAD: begin
        ram_re    = 1'b1;
        ram_raddr = ring_pos(head, idx_inc);
      end
      S_SWRITE: begin
        ram_we    = 1'b1;
        ram_waddr = ring_pos(head, idx);
        ram_wdata = ram_rdata;
        out_load  = !(idx_inc2 < count);
      end
      S_VOUT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  bcle_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key         <= value;
            idx         <= '0;
            last_of_run <= 1'b1;
            item_value  <= value;
            unique case (func)
              FUNC_INS_FRONT, FUNC_INS_END: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_DONE;
                  count  <= count + CNT_W'(1);
                  if (func == FUNC_INS_FRONT) begin
                    head <= head_dec;
                  end
                end
              end
              FUNC_DELETE: begin
                if (count == '0) begin
                  status    <= ST_EMPTY;
                end else begin
                  state <= S_DREAD;
                end
              end
              default: begin
                if (count == '0) begin
                  status     <= ST_EMPTY;
                  item_value <= '0;
                end else begin
                  state <= S_VREAD;
                end
              end
            endcase
          end
        end
        S_DREAD: begin
          state <= S_DCMP;
        end
        S_DCMP: begin
          if (ram_rdata == key) begin
            if (idx_inc < count) begin
              state <= S_SREAD;
            end else begin
              count       <= count - CNT_W'(1);
              status      <= ST_DONE;
              item_value  <= key;
              last_of_run <= 1'b1;
              state       <= S_IDLE;
            end
          end else if (idx_inc < count) begin
            idx   <= idx_inc;
            state <= S_DREAD;
          end else begin
            status      <= ST_NOT_FOUND;
            item_value  <= key;
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_SREAD: begin
          state <= S_SWRITE;
        end
        S_SWRITE: begin
          idx <= idx_inc;
          if (idx_inc2 < count) begin
            state <= S_SREAD;
          end else begin
            count       <= count - CNT_W'(1);
            status      <= ST_DONE;
            item_value  <= key;
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_VREAD: begin
          state <= S_VOUT;
        end
        S_VOUT: begin
          if (out_free) begin
            status      <= ST_SHOWN;
            item_value  <= ram_rdata;
            last_of_run <= (idx_inc == count);
            if (idx_inc == count) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx_inc;
              state <= S_VREAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/bcle_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bcle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
